### rtl/bfps_pkg.sv
`timescale 1ns / 1ps

package bfps_pkg;

  localparam int unsigned DEPTH        = 16;
  localparam int unsigned OBJECT_WIDTH = 32;
  localparam int unsigned AW           = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW           = $clog2(DEPTH + 1);
  localparam int unsigned CAP_W        = 5;
  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

  typedef enum logic [1:0] {
    OP_PUT  = 2'd0,
    OP_GET  = 2'd1,
    OP_FIND = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef struct packed {
    logic [1:0]              operation;
    logic [OBJECT_WIDTH-1:0] object_value;
  } in_word_t;

  typedef struct packed {
    logic [1:0]              status;
    logic [OBJECT_WIDTH-1:0] object_out;
    logic [CW-1:0]           position;
    logic [CW-1:0]           fill_level;
  } out_word_t;

  function automatic logic [AW-1:0] next_slot(input logic [AW-1:0] idx);
    logic [AW-1:0] nxt;
    nxt = (idx == AW'(DEPTH - 1)) ? '0 : idx + AW'(1);
    return nxt;
  endfunction

endpackage

### rtl/bounded_fifo_with_position_search_top.sv
`timescale 1ns / 1ps

// Bounded FIFO of object words with a position search.
// Input channel (in_valid_i / in_ready_o / in_word_i): one word carries an
// operation (put, get, find) and an object word. Output channel
// (out_valid_o / out_ready_i / out_word_o): one result word per input word,
// with status, the removed object (get), the 1-based match position (find)
// and the fill level after the operation.
// cfg_we_i / cfg_wdata_i write the capacity limit (reset 16, saturates at
// the store depth, 0 refuses every put).
// Put, refused get, find on an empty queue and unknown codes go from idle
// to the response state, which loads the output register; a successful get
// first waits in S_GET for the head read data. A find walks the entries
// from the head through the store's read port, a read state and then a
// compare state per entry, up to DEPTH entries, stopping at a match.
// One operation is in flight at a time; in_ready_o is high only while the
// sequencer is idle. A finished result waits in the output register; if
// the receiver stalls while another result is ready, the sequencer holds
// in its response state until the register frees up.
// Reset empties the queue (head, tail, count cleared) and restores the
// capacity; stored words are not cleared, they are only read once written.
module bounded_fifo_with_position_search_top (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  bfps_pkg::in_word_t         in_word_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output bfps_pkg::out_word_t        out_word_o,
  input  logic                       cfg_we_i,
  input  logic [bfps_pkg::CAP_W-1:0] cfg_wdata_i
);

  import bfps_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_GET  = 5'b00010,  // wait for head read data
    S_FRD  = 5'b00100,  // issue read at walk slot
    S_FCMP = 5'b01000,  // compare walk slot data
    S_RESP = 5'b10000   // push result to output register
  } state_e;

  state_e                  state_q, state_d;
  logic [AW-1:0]           head_q, head_d;
  logic [AW-1:0]           tail_q, tail_d;
  logic [CW-1:0]           count_q, count_d;
  logic [CAP_W-1:0]        cap_q;
  logic [AW-1:0]           slot_q, slot_d;
  logic [CW-1:0]           k_q, k_d;
  logic [OBJECT_WIDTH-1:0] obj_q, obj_d;
  logic [1:0]              res_status_q, res_status_d;
  logic [OBJECT_WIDTH-1:0] res_obj_q, res_obj_d;
  logic [CW-1:0]           res_pos_q, res_pos_d;
  logic                    out_valid_q, out_valid_d;
  out_word_t               out_word_q, out_word_d;

  logic                    accept;
  logic                    can_put;
  logic                    ram_we;
  logic [AW-1:0]           ram_raddr;
  logic [OBJECT_WIDTH-1:0] ram_rdata;
  logic                    out_free;

  assign accept   = in_valid_i && in_ready_o;
  assign out_free = !out_valid_q || out_ready_i;
  // count never exceeds DEPTH; a capacity above DEPTH saturates there
  assign can_put  = (CW'(count_q) < CW'(cap_q)) && (count_q != CW'(DEPTH));
  assign ram_we   = accept && (in_word_i.operation == OP_PUT) && can_put;
  assign ram_raddr = (state_q == S_IDLE) ? head_q : slot_q;

  bfps_ram #(
    .WIDTH(OBJECT_WIDTH),
    .DEPTH(DEPTH)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(tail_q),
    .wdata_i(in_word_i.object_value),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  always_comb begin
    state_d      = state_q;
    head_d       = head_q;
    tail_d       = tail_q;
    count_d      = count_q;
    slot_d       = slot_q;
    k_d          = k_q;
    obj_d        = obj_q;
    res_status_d = res_status_q;
    res_obj_d    = res_obj_q;
    res_pos_d    = res_pos_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    out_word_d   = out_word_q;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          res_status_d = ST_OK;
          res_obj_d    = '0;
          res_pos_d    = '0;
          obj_d        = in_word_i.object_value;
          state_d      = S_RESP;
          unique case (in_word_i.operation)
            OP_PUT: begin
              if (can_put) begin
                tail_d  = next_slot(tail_q);
                count_d = count_q + CW'(1);
              end else begin
                res_status_d = ST_FULL;
              end
            end
            OP_GET: begin
              if (count_q != '0) begin
                // head read issued this cycle
                head_d  = next_slot(head_q);
                count_d = count_q - CW'(1);
                state_d = S_GET;
              end else begin
                res_status_d = ST_EMPTY;
              end
            end
            OP_FIND: begin
              if (count_q != '0) begin
                slot_d  = head_q;
                k_d     = '0;
                state_d = S_FRD;
              end
            end
            default: ;  // unused code: no change
          endcase
        end
      end
      S_GET: begin
        res_obj_d = ram_rdata;
        state_d   = S_RESP;
      end
      S_FRD: begin
        state_d = S_FCMP;
      end
      S_FCMP: begin
        if (ram_rdata == obj_q) begin
          res_pos_d = k_q + CW'(1);
          state_d   = S_RESP;
        end else if (k_q + CW'(1) == count_q) begin
          state_d = S_RESP;
        end else begin
          k_d     = k_q + CW'(1);
          slot_d  = next_slot(slot_q);
          state_d = S_FRD;
        end
      end
      S_RESP: begin
        if (out_free) begin
          out_valid_d           = 1'b1;
          out_word_d.status     = res_status_q;
          out_word_d.object_out = res_obj_q;
          out_word_d.position   = res_pos_q;
          out_word_d.fill_level = count_q;
          state_d               = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      head_q      <= '0;
      tail_q      <= '0;
      count_q     <= '0;
      cap_q       <= CAP_RESET;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    slot_q       <= slot_d;
    k_q          <= k_d;
    obj_q        <= obj_d;
    res_status_q <= res_status_d;
    res_obj_q    <= res_obj_d;
    res_pos_q    <= res_pos_d;
    out_word_q   <= out_word_d;
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(DEPTH))
    else $error("fill count above depth");

  a_put_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (in_word_i.operation == OP_PUT) && can_put)
      |=> (count_q == $past(count_q) + CW'(1)))
    else $error("accepted put did not grow the queue");

  a_walk_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_FRD) || (state_q == S_FCMP)) |-> (k_q < count_q))
    else $error("find walk past the tail");

  a_resp_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_RESP) && out_free) |=> (out_valid_q && (state_q == S_IDLE)))
    else $error("result not loaded into output register");
`endif

endmodule

### rtl/bfps_ram.sv
`timescale 1ns / 1ps

module bfps_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                       clk_i,
  input  logic                                       we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                           wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                           rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### tb/sv/bfps_queue_checker.sv
`timescale 1ns / 1ps

// Watches both channels and the capacity port of the queue, keeps a private
// copy of the queue, and checks every result word against it in order.
module bfps_queue_checker (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  input  logic                       in_ready_i,
  input  bfps_pkg::in_word_t         in_word_i,
  input  logic                       out_valid_i,
  input  logic                       out_ready_i,
  input  bfps_pkg::out_word_t        out_word_i,
  input  logic                       cfg_we_i,
  input  logic [bfps_pkg::CAP_W-1:0] cfg_wdata_i,
  output int unsigned                pending_o,
  output int unsigned                mismatch_count_o
);

  import bfps_pkg::*;

  localparam int unsigned REPORT_LIMIT = 10;

  // private copy of the queue
  logic [OBJECT_WIDTH-1:0] held_words [DEPTH];
  logic [AW-1:0]           head_slot;
  logic [AW-1:0]           tail_slot;
  logic [CW-1:0]           held_count;
  logic [CAP_W-1:0]        capacity;

  out_word_t   expected_results [$];
  out_word_t   want;
  out_word_t   predicted;
  int unsigned mismatches;
  int unsigned results_seen;

  task automatic run_queue_op(input in_word_t w, output out_word_t r);
    int unsigned   eff_cap;
    int unsigned   k;
    logic [AW-1:0] slot;
    logic          found;
    eff_cap = (capacity > DEPTH) ? DEPTH : capacity;
    r = '0;
    r.status = ST_OK;
    case (w.operation)
      OP_PUT: begin
        if (held_count < eff_cap) begin
          held_words[tail_slot] = w.object_value;
          tail_slot = AW'((tail_slot + 1) % DEPTH);
          held_count = held_count + 1'b1;
        end else begin
          r.status = ST_FULL;
        end
      end
      OP_GET: begin
        if (held_count != 0) begin
          r.object_out = held_words[head_slot];
          head_slot = AW'((head_slot + 1) % DEPTH);
          held_count = held_count - 1'b1;
        end else begin
          r.status = ST_EMPTY;
        end
      end
      OP_FIND: begin
        slot = head_slot;
        found = 1'b0;
        for (k = 0; k < held_count; k++) begin
          if (!found && held_words[slot] == w.object_value) begin
            r.position = CW'(k + 1);
            found = 1'b1;
          end
          slot = AW'((slot + 1) % DEPTH);
        end
      end
      default: ;  // unused code: no change
    endcase
    r.fill_level = held_count;
  endtask

  task automatic note_mismatch(input logic unexpected, input out_word_t exp_w,
                               input out_word_t got_w);
    mismatches++;
    if (mismatches <= REPORT_LIMIT) begin
      if (unexpected) begin
        $display("result %0d: unexpected word status %0d object %h position %0d fill %0d",
                 results_seen, got_w.status, got_w.object_out, got_w.position,
                 got_w.fill_level);
      end else begin
        $display("result %0d: exp/act status %0d/%0d object %h/%h position %0d/%0d fill %0d/%0d",
                 results_seen, exp_w.status, got_w.status, exp_w.object_out,
                 got_w.object_out, exp_w.position, got_w.position, exp_w.fill_level,
                 got_w.fill_level);
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_slot = '0;
      tail_slot = '0;
      held_count = '0;
      capacity = CAP_RESET;
      expected_results.delete();
      mismatches = 0;
      results_seen = 0;
      pending_o <= 0;
      mismatch_count_o <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          note_mismatch(1'b1, '0, out_word_i);
        end else begin
          want = expected_results.pop_front();
          if (want.status !== out_word_i.status || want.object_out !== out_word_i.object_out ||
              want.position !== out_word_i.position ||
              want.fill_level !== out_word_i.fill_level) begin
            note_mismatch(1'b0, want, out_word_i);
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        run_queue_op(in_word_i, predicted);
        expected_results.push_back(predicted);
      end
      // a capacity write takes effect after this edge
      if (cfg_we_i) begin
        capacity = cfg_wdata_i;
      end
      pending_o <= expected_results.size();
      mismatch_count_o <= mismatches;
    end
  end

endmodule

### tb/sv/bounded_fifo_with_position_search_top_tb.sv
`timescale 1ns / 1ps

// Stimulus and verdict for the bounded FIFO with position search.
// The checker beside the DUT does all prediction and comparison; this module
// only makes words, idles both sides and reports the outcome.
module bounded_fifo_with_position_search_top_tb;
  import bfps_pkg::*;

  // code 3 has no operation behind it; the queue must leave everything alone
  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam int unsigned IDLE_PCT      = 30;
  localparam int unsigned NUM_PHASES    = 5;
  localparam int unsigned PHASE_WORDS   = 100;
  // a find walks at most DEPTH entries, a read and a compare for each
  localparam int unsigned SETTLE_CYCLES = 2 * DEPTH + 8;
  localparam int unsigned CYCLE_LIMIT   = 400000;

  logic                    clk       = 1'b0;
  logic                    rst_n     = 1'b0;
  logic                    in_valid  = 1'b0;
  logic                    in_ready;
  in_word_t                in_word   = '0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  out_word_t               out_word;
  logic                    cfg_we    = 1'b0;
  logic [CAP_W-1:0]        cfg_wdata = '0;

  int unsigned             pending;
  int unsigned             mismatch_count;
  int unsigned             cycles = 0;
  // set during one phase to give a long stretch with no idling on either side
  logic                    steady = 1'b0;

  // a handful of recurring words so that finds hit and duplicates occur
  logic [OBJECT_WIDTH-1:0] word_pool [8];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  bounded_fifo_with_position_search_top dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_word_i   (in_word),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_word_o  (out_word),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata)
  );

  bfps_queue_checker checker_i (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_ready_i       (in_ready),
    .in_word_i        (in_word),
    .out_valid_i      (out_valid),
    .out_ready_i      (out_ready),
    .out_word_i       (out_word),
    .cfg_we_i         (cfg_we),
    .cfg_wdata_i      (cfg_wdata),
    .pending_o        (pending),
    .mismatch_count_o (mismatch_count)
  );

  // Receiver: stalls about 30% of cycles, never while steady.
  always @(posedge clk) begin
    out_ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  // Watchdog; the slowest correct run is far below this.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Offer one word and hold it until the DUT takes it. Random gaps ahead of
  // the word; valid is only ever assigned once per edge.
  task automatic send_word(input logic [1:0] op, input logic [OBJECT_WIDTH-1:0] value);
    while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= '{operation: op, object_value: value};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Let every result come back, then a few quiet cycles, so the queue is idle.
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Capacity is only written with the queue idle.
  task automatic set_capacity(input logic [CAP_W-1:0] cap);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_wdata <= cap;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Pool words in 45% of picks, otherwise any 32-bit value.
  function automatic logic [OBJECT_WIDTH-1:0] pick_word();
    if ($urandom_range(0, 99) < 45) return word_pool[$urandom_range(0, 7)];
    return $urandom;
  endfunction

  // Per-phase capacity and operation mix. The first phase pushes against the
  // depth with a capacity above it; the second drops the capacity below what is
  // held and drains; the third runs without idling; the fourth has room for
  // one entry only.
  logic [CAP_W-1:0] phase_cap [NUM_PHASES];
  int unsigned      put_pct   [NUM_PHASES] = '{60, 30, 55, 40, 45};
  int unsigned      get_pct   [NUM_PHASES] = '{20, 45, 25, 30, 35};

  initial begin
    int unsigned   ph;
    int unsigned   n;
    int unsigned   roll;
    logic [1:0]    op;

    word_pool[0] = '0;
    word_pool[1] = '1;
    for (n = 2; n < 8; n++) word_pool[n] = $urandom;
    phase_cap = '{CAP_W'(31), CAP_W'(6), CAP_W'(16), CAP_W'(1),
                  CAP_W'($urandom_range(2, 15))};

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty queue, unused code, extremes of the word, duplicates
    set_capacity(CAP_W'(16));
    send_word(OP_GET, 32'h0000_0000);              // empty get
    send_word(OP_FIND, 32'hFFFF_FFFF);             // find on empty queue
    send_word(OP_UNUSED, 32'hFFFF_FFFF);
    send_word(OP_PUT, 32'h0000_0000);
    send_word(OP_PUT, 32'hFFFF_FFFF);
    send_word(OP_PUT, 32'hA5A5_A5A5);
    send_word(OP_PUT, 32'hFFFF_FFFF);              // duplicate
    send_word(OP_FIND, 32'hFFFF_FFFF);             // first of two matches
    send_word(OP_FIND, 32'h0000_0000);             // at the head
    send_word(OP_FIND, 32'hA5A5_A5A5);
    send_word(OP_FIND, 32'h1234_5678);             // absent
    send_word(OP_UNUSED, 32'h5A5A_5A5A);
    send_word(OP_GET, 32'hFFFF_FFFF);
    send_word(OP_GET, 32'h0000_0000);
    send_word(OP_FIND, 32'hFFFF_FFFF);

    // two held; capacity 2 refuses the next put
    set_capacity(CAP_W'(2));
    send_word(OP_PUT, 32'h0000_0001);
    // capacity below what is held: puts refused until gets make room
    set_capacity(CAP_W'(1));
    send_word(OP_PUT, 32'h0000_0002);
    send_word(OP_GET, 32'h0000_0000);
    send_word(OP_PUT, 32'h0000_0003);
    send_word(OP_GET, 32'h0000_0000);
    send_word(OP_PUT, 32'h0000_0007);
    // capacity zero refuses every put
    set_capacity(CAP_W'(0));
    send_word(OP_PUT, 32'h8000_0000);
    send_word(OP_FIND, 32'h0000_0007);
    send_word(OP_GET, 32'h0000_0000);

    // Random phases
    for (ph = 0; ph < NUM_PHASES; ph++) begin
      set_capacity(phase_cap[ph]);
      steady = (ph == 2);
      for (n = 0; n < PHASE_WORDS; n++) begin
        roll = $urandom_range(0, 99);
        if (roll < put_pct[ph]) op = OP_PUT;
        else if (roll < put_pct[ph] + get_pct[ph]) op = OP_GET;
        else if (roll < 97) op = OP_FIND;
        else op = OP_UNUSED;
        send_word(op, pick_word());
      end
      steady = 1'b0;
    end

    // everything sent: wait out the last results, then decide
    wait_idle();
    if (mismatch_count == 0 && pending == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
